@@ design/column_melt_transition_macros.svh @@
// Assertion macros used by the checker of the column melt transition block.
// Needs clk and arst_n to be visible at the place of use.
`ifndef COLUMN_MELT_TRANSITION_MACROS_SVH
`define COLUMN_MELT_TRANSITION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("column_melt_transition: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("column_melt_transition: next-cycle check failed");

`endif

@@ design/cmt_pkg.sv @@
// Package of the column melt transition block: opcodes, register indexes,
// step constants and parameter defaults. No dependencies.
`default_nettype none

package cmt_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 256;

	localparam int FAST_LIMIT     = 16;
	localparam int SLOW_STEP      = 8;
	localparam int EARLIEST_START = -15;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 4'd1;

	localparam logic [CFG_DATA_W-1:0] ROWS_RESET    = 9'd200;
	localparam logic [CFG_DATA_W-1:0] COLUMNS_RESET = 9'd160;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

endpackage

`default_nettype wire

@@ design/cmt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
`default_nettype none

module cmt_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/column_melt_transition.sv @@
// Column melt transition: a load passes ST_FIN before out_valid rises, a query passes ST_QRY
// and ST_FIN, and a tick takes longer with a larger tick_count and more columns in use, as the
// offset RAM gives one read per cycle and the walk visits each column once per tick.
// One transaction is in progress at a time; the next can be accepted in the cycle after a result is
// registered, and a finished result may wait in the output register.
// After reset a clearing pass zeroes every offset entry; inputs stall during it.
`default_nettype none

module column_melt_transition #(
	parameter int MAX_COLUMNS = cmt_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = cmt_pkg::MAX_ROWS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [cmt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [cmt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire [1:0]                       opcode,
	input  wire [7:0]                       column,
	input  wire signed [4:0]                start_offset,
	input  wire [7:0]                       row,
	input  wire [3:0]                       tick_count,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic                            done_res,
	output logic                            from_end,
	output logic [7:0]                      source_row
);

	import cmt_pkg::*;

	localparam int IDX_W = $clog2(MAX_COLUMNS);
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int OFS_W = ROW_W + 1;
	localparam int EXT_W = OFS_W + 1;
	localparam int QRY_W = ((OFS_W > 9) ? OFS_W : 9) + 1;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_TICK = 3'd2;
	localparam logic [2:0] ST_QRY  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       clr_idx_q;
	logic [CFG_DATA_W-1:0]  rows_q;
	logic [CFG_DATA_W-1:0]  cols_q;
	logic [3:0]             ticks_left_q;
	logic [IDX_W-1:0]       rd_col_q;
	logic                   issue_q;
	logic                   finished_q;
	logic                   valid_s1;
	logic [IDX_W-1:0]       addr_s1;
	logic                   fwd_s1;
	logic [OFS_W-1:0]       fwd_data_s1;
	logic [7:0]             row_q;
	logic                   in_range_q;
	logic                   res_done_q;
	logic                   res_from_end_q;
	logic [7:0]             res_src_q;
	logic                   out_valid_q;
	logic                   done_q;
	logic                   from_end_q;
	logic [7:0]             source_row_q;

	logic                   in_accept;
	logic                   col_ok;
	logic [IDX_W-1:0]       col_addr;
	logic signed [4:0]      start_clip;
	logic [OFS_W-1:0]       load_val;
	logic [ROW_W-1:0]       eff_rows;
	logic [CNT_W-1:0]       eff_cols;
	logic                   last_col;
	logic                   tick_rd;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [OFS_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [IDX_W-1:0]       ram_raddr;
	logic [OFS_W-1:0]       ram_rdata;

	logic signed [EXT_W-1:0] y_ext;
	logic signed [EXT_W-1:0] h_ext;
	logic signed [EXT_W-1:0] dy;
	logic signed [EXT_W-1:0] sum;
	logic signed [EXT_W-1:0] new_ext;
	logic                    active;
	logic [OFS_W-1:0]        cur_y;

	logic signed [QRY_W-1:0] q_y;
	logic signed [QRY_W-1:0] q_row;
	logic signed [QRY_W-1:0] q_diff;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign done_res   = done_q;
	assign from_end   = from_end_q;
	assign source_row = source_row_q;

	assign col_ok   = (32'(column) < MAX_COLUMNS);
	assign col_addr = IDX_W'(column);
	assign eff_rows = (32'(rows_q) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(rows_q);
	assign eff_cols = (32'(cols_q) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) : CNT_W'(cols_q);
	assign last_col = ((CNT_W'(rd_col_q) + CNT_W'(1)) == eff_cols);
	assign tick_rd  = (state_q == ST_TICK) && issue_q;

	always_comb begin
		start_clip = start_offset;
		if (start_offset > 5'sd0) begin
			start_clip = 5'sd0;
		end else if (start_offset < EARLIEST_START) begin
			start_clip = 5'(EARLIEST_START);
		end
		load_val = {{(OFS_W-5){start_clip[4]}}, start_clip};
	end

	// One column step: delayed columns count up, moving ones grow fast then slow,
	// clipped to the row count; columns at or past the row count stay put.
	assign cur_y = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		y_ext   = {cur_y[OFS_W-1], cur_y};
		h_ext   = {{(EXT_W-ROW_W){1'b0}}, eff_rows};
		dy      = '0;
		sum     = '0;
		new_ext = y_ext;
		active  = 1'b0;
		if (y_ext < 0) begin
			new_ext = y_ext + EXT_W'(1);
			active  = 1'b1;
		end else if (y_ext < h_ext) begin
			dy      = (y_ext < FAST_LIMIT) ? (y_ext + EXT_W'(1)) : EXT_W'(SLOW_STEP);
			sum     = y_ext + dy;
			new_ext = (sum >= h_ext) ? h_ext : sum;
			active  = 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = new_ext[OFS_W-1:0];
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_we    = in_accept && (opcode == OP_LOAD) && col_ok;
				ram_waddr = col_addr;
				ram_wdata = load_val;
			end
			ST_TICK: begin
				ram_we = valid_s1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re    = tick_rd || (in_accept && (opcode == OP_QUERY));
	assign ram_raddr = tick_rd ? rd_col_q : col_addr;

	cmt_ram #(
		.WIDTH(OFS_W),
		.DEPTH(MAX_COLUMNS)
	) u_offsets (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		q_y    = in_range_q ? {{(QRY_W-OFS_W){ram_rdata[OFS_W-1]}}, ram_rdata} : '0;
		q_row  = {{(QRY_W-8){1'b0}}, row_q};
		q_diff = q_row - q_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLUMNS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS_IN_USE) begin
				rows_q <= cfg_data;
			end else if (cfg_index == REG_COLUMNS_IN_USE) begin
				cols_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_idx_q    <= '0;
			issue_q      <= 1'b0;
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			ticks_left_q <= '0;
			rd_col_q     <= '0;
			finished_q   <= 1'b1;
		end else begin
			valid_s1 <= tick_rd;
			// A tick read of the entry being written this cycle takes the new value.
			fwd_s1   <= tick_rd && ram_we && (ram_waddr == rd_col_q);
			if ((state_q == ST_FIN) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(MAX_COLUMNS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						case (opcode)
							OP_TICK: begin
								if ((eff_cols == '0) || (tick_count == 4'd0)) begin
									state_q <= ST_FIN;
								end else begin
									issue_q      <= 1'b1;
									ticks_left_q <= tick_count;
									rd_col_q     <= '0;
									finished_q   <= 1'b1;
									state_q      <= ST_TICK;
								end
							end
							OP_QUERY: begin
								state_q <= ST_QRY;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_TICK: begin
					if (issue_q) begin
						if (last_col) begin
							rd_col_q <= '0;
							if (ticks_left_q == 4'd1) begin
								issue_q <= 1'b0;
							end else begin
								ticks_left_q <= ticks_left_q - 4'd1;
							end
						end else begin
							rd_col_q <= rd_col_q + IDX_W'(1);
						end
					end
					if (valid_s1 && active) begin
						finished_q <= 1'b0;
					end
					if (!issue_q && !valid_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_QRY: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: result staging, stage-one data and output fields.
	always_ff @(posedge clk) begin
		addr_s1     <= rd_col_q;
		fwd_data_s1 <= ram_wdata;
		if (in_accept) begin
			row_q          <= row;
			in_range_q     <= col_ok;
			res_from_end_q <= 1'b0;
			res_src_q      <= '0;
			res_done_q     <= (opcode == OP_TICK) &&
				((eff_cols == '0) || (tick_count == 4'd0));
		end
		if ((state_q == ST_TICK) && !issue_q && !valid_s1) begin
			res_done_q <= finished_q;
		end
		if (state_q == ST_QRY) begin
			if ((q_y > 0) && (q_row < q_y)) begin
				res_from_end_q <= 1'b1;
				res_src_q      <= row_q;
			end else if (q_y > 0) begin
				res_src_q <= q_diff[7:0];
			end else begin
				res_src_q <= row_q;
			end
		end
		if ((state_q == ST_FIN) && (!out_valid_q || !out_stall)) begin
			done_q       <= res_done_q;
			from_end_q   <= res_from_end_q;
			source_row_q <= res_src_q;
		end
	end

endmodule

`default_nettype wire

@@ design/cmt_checker.sv @@
// Port-level checker for the column melt transition block, bound to its top level.
// Depends on column_melt_transition_macros.svh.
`default_nettype none

`include "column_melt_transition_macros.svh"

module cmt_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire       out_valid,
	input wire       out_stall,
	input wire       done_res,
	input wire       from_end,
	input wire [7:0] source_row
);

	// A result waiting on a stalled receiver keeps its transaction intact.
	`CMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(done_res) && $stable(from_end) && $stable(source_row))

	// Only one transaction is worked on, so the input side closes after each one.
	`CMT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A finished tick result carries no query answer.
	`CMT_ASSERT_SAME(a_done_exclusive, out_valid && done_res, !from_end && (source_row == 8'd0))

endmodule

bind column_melt_transition cmt_checker u_cmt_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for column_melt_transition: loads, ticks and queries
// are predicted in the bench and each result is compared as it leaves the block.
// Depends on cmt_pkg and the column_melt_transition RTL.
`timescale 1ns / 100ps

module tb;
	import cmt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 64'd20_000_000;
	localparam int RANDOM_ITEMS = 1250;

	typedef struct {
		logic       done;
		logic       from_end;
		logic [7:0] src;
	} melt_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = OP_LOAD;
	logic [7:0] column = '0;
	logic [4:0] start_offset = '0;
	logic [7:0] row = '0;
	logic [3:0] tick_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic done_res;
	logic from_end;
	logic [7:0] source_row;

	// Bench copy of the block state and registers.
	int drop_ofs [MAX_COLUMNS_DEF];
	logic [CFG_DATA_W-1:0] rows_reg = ROWS_RESET;
	logic [CFG_DATA_W-1:0] cols_reg = COLUMNS_RESET;

	melt_answer_t answers_due [$];
	int errors = 0;
	int items_sent = 0;
	longint cycles = 0;
	bit sender_calm = 1'b0;
	bit sink_calm = 1'b0;

	column_melt_transition dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .column(column), .start_offset(start_offset),
		.row(row), .tick_count(tick_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.done_res(done_res), .from_end(from_end), .source_row(source_row)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Applies one transaction to the bench state and returns its answer.
	function automatic melt_answer_t melt_step(logic [1:0] op, logic [7:0] col,
			logic [4:0] start, logic [7:0] c_row, logic [3:0] ticks);
		melt_answer_t a;
		int h, w, y, dy, s, r;
		bit moved;
		a = '{done: 1'b0, from_end: 1'b0, src: 8'd0};
		h = (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
		w = (cols_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cols_reg);
		r = int'(c_row);
		case (op)
			OP_LOAD: begin
				s = int'($signed(start));
				if (s > 0)
					s = 0;
				if (s < EARLIEST_START)
					s = EARLIEST_START;
				drop_ofs[col] = s;
			end
			OP_TICK: begin
				moved = 1'b0;
				for (int t = 0; t < int'(ticks); t++)
					for (int i = 0; i < w; i++) begin
						y = drop_ofs[i];
						if (y < 0) begin
							y++;
							moved = 1'b1;
						end else if (y < h) begin
							dy = (y < FAST_LIMIT) ? y + 1 : SLOW_STEP;
							if (y + dy >= h)
								dy = h - y;
							y += dy;
							moved = 1'b1;
						end
						drop_ofs[i] = y;
					end
				a.done = !moved;
			end
			OP_QUERY: begin
				y = drop_ofs[col];
				if (y > 0 && r < y) begin
					a.from_end = 1'b1;
					a.src = 8'(r);
				end else if (y > 0) begin
					a.src = 8'(r - y);
				end else begin
					a.src = 8'(r);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic send_cmd(input logic [1:0] op, input logic [7:0] col,
			input logic [4:0] start, input logic [7:0] c_row, input logic [3:0] ticks,
			output melt_answer_t ans);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		column <= col;
		start_offset <= start;
		row <= c_row;
		tick_count <= ticks;
		do
			@(posedge clk);
		while (in_stall);
		ans = melt_step(op, col, start, c_row, ticks);
		answers_due.push_back(ans);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Stops sending and waits for every outstanding result.
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain_block();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS_IN_USE)
			rows_reg = val;
		else if (idx == REG_COLUMNS_IN_USE)
			cols_reg = val;
	endtask

	// The sink draws a fresh stall length for every result it takes.
	initial begin
		int n;
		forever begin
			n = sink_calm ? 0 : $urandom_range(0, 14);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(arst_n && out_valid));
		end
	end

	always @(posedge clk) begin : check_results
		melt_answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (done_res !== want.done) begin
					$error("done_res: expected %0d, got %0d", want.done, done_res);
					errors++;
				end
				if (from_end !== want.from_end) begin
					$error("from_end: expected %0d, got %0d", want.from_end, from_end);
					errors++;
				end
				if (source_row !== want.src) begin
					$error("source_row: expected %0d, got %0d", want.src, source_row);
					errors++;
				end
			end
		end
	end

	task automatic test_after_reset();
		melt_answer_t a;
		send_cmd(OP_QUERY, 8'd0, 5'd0, 8'd255, 4'd0, a);
		send_cmd(OP_UNUSED, 8'd255, 5'b11111, 8'd255, 4'd15, a);
		send_cmd(OP_TICK, 8'd0, 5'd0, 8'd0, 4'd1, a);
	endtask

	// Out-of-range starts are clamped: positive to zero, -16 to -15.
	task automatic test_load_limits();
		melt_answer_t a;
		send_cmd(OP_LOAD, 8'd0, 5'b10000, 8'd0, 4'd0, a);
		send_cmd(OP_LOAD, 8'd255, 5'b01111, 8'd0, 4'd0, a);
		send_cmd(OP_LOAD, 8'd1, 5'b00001, 8'd0, 4'd0, a);
		send_cmd(OP_LOAD, 8'd2, 5'b11111, 8'd0, 4'd0, a);
		send_cmd(OP_LOAD, 8'd3, 5'b00000, 8'd0, 4'd0, a);
		send_cmd(OP_QUERY, 8'd0, 5'd0, 8'd0, 4'd0, a);
	endtask

	task automatic test_register_extremes();
		melt_answer_t a;
		write_reg(REG_COLUMNS_IN_USE, 9'd0);
		write_reg(REG_ROWS_IN_USE, 9'd1);
		send_cmd(OP_TICK, 8'd0, 5'd0, 8'd0, 4'd15, a);
		write_reg(4'd15, 9'h1FF);
		write_reg(REG_COLUMNS_IN_USE, 9'h1FF);
		write_reg(REG_ROWS_IN_USE, 9'd0);
		// With no rows only the delayed columns move.
		send_cmd(OP_TICK, 8'd0, 5'd0, 8'd0, 4'd15, a);
		send_cmd(OP_TICK, 8'd0, 5'd0, 8'd0, 4'd0, a);
		write_reg(REG_ROWS_IN_USE, 9'h1FF);
		do
			send_cmd(OP_TICK, 8'd0, 5'd0, 8'd0, 4'd15, a);
		while (!a.done);
		send_cmd(OP_QUERY, 8'd0, 5'd0, 8'd255, 4'd0, a);
		send_cmd(OP_QUERY, 8'd5, 5'd0, 8'd0, 4'd0, a);
		// Columns beyond a reduced row count no longer move.
		write_reg(REG_ROWS_IN_USE, 9'd16);
		send_cmd(OP_TICK, 8'd0, 5'd0, 8'd0, 4'd1, a);
	endtask

	task automatic test_offset_query();
		melt_answer_t a;
		write_reg(REG_ROWS_IN_USE, 9'd200);
		write_reg(REG_COLUMNS_IN_USE, 9'd8);
		send_cmd(OP_LOAD, 8'd1, 5'd0, 8'd0, 4'd0, a);
		send_cmd(OP_TICK, 8'd0, 5'd0, 8'd0, 4'd2, a);
		send_cmd(OP_QUERY, 8'd1, 5'd0, 8'd2, 4'd0, a);
		send_cmd(OP_QUERY, 8'd1, 5'd0, 8'd3, 4'd0, a);
		send_cmd(OP_QUERY, 8'd1, 5'd0, 8'd255, 4'd0, a);
	endtask

	// Whole transitions: set up, load the columns, tick until done, with queries
	// and stray transactions mixed in.
	task automatic test_random_melts();
		melt_answer_t a;
		int w, nload, tick_items;
		logic [CFG_DATA_W-1:0] rows_val, cols_val;
		logic [4:0] start;
		logic [3:0] ticks;
		while (items_sent < RANDOM_ITEMS) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: rows_val = 9'($urandom_range(257, 511));
				1: rows_val = 9'd0;
				default: rows_val = 9'($urandom_range(1, 256));
			endcase
			case ($urandom_range(0, 9))
				0: cols_val = 9'($urandom_range(0, 511));
				1: cols_val = 9'd256;
				default: cols_val = 9'($urandom_range(1, 24));
			endcase
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_IDX_W'($urandom_range(2, 15)), 9'($urandom));
			write_reg(REG_ROWS_IN_USE, rows_val);
			write_reg(REG_COLUMNS_IN_USE, cols_val);
			w = (cols_val > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cols_val);
			nload = (w <= 32) ? w : 24;
			for (int k = 0; k < nload; k++) begin
				if ($urandom_range(0, 4) == 0)
					start = 5'($urandom);
				else
					start = 5'(-int'($urandom_range(0, 15)));
				send_cmd(OP_LOAD, (w <= 32) ? 8'(k) : 8'($urandom_range(0, w - 1)),
					start, 8'($urandom), 4'($urandom), a);
				if ($urandom_range(0, 9) == 0)
					send_cmd(2'($urandom), 8'($urandom), 5'($urandom), 8'($urandom),
						4'($urandom), a);
			end
			if ($urandom_range(0, 2) == 0)
				drain_block();
			tick_items = 0;
			do begin
				ticks = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 4));
				send_cmd(OP_TICK, 8'($urandom), 5'($urandom), 8'($urandom), ticks, a);
				tick_tems_guard: tick_items++;
				repeat ($urandom_range(0, 2))
					send_cmd(OP_QUERY, ($urandom_range(0, 3) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, (w > 0) ? w - 1 : 0)),
						5'($urandom), 8'($urandom), 4'($urandom), a);
			end while (!a.done && tick_items < 120);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_after_reset();
		test_load_limits();
		test_register_extremes();
		test_offset_query();
		test_random_melts();
		drain_block();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
